FILE: hdl/tcpu_pkg.sv
// Shared types, constants and decode helpers for the tiny CPU step block.
// No dependencies; imported by every other file of the block but tcpu_ram.
`default_nettype none

package tcpu_pkg;

  localparam int MEMORY_WORDS_DEF = 512;
  localparam int REG_COUNT        = 16;
  localparam int REG_AW           = 4;
  localparam int WORD_W           = 16;
  localparam int LOC_W            = 9;
  localparam int MODE_W           = 2;
  localparam int PC_OUT_W         = 9;
  localparam int IN_TDATA_W       = 32;
  localparam int OUT_TDATA_W      = 32;
  localparam int OUT_USED_W       = PC_OUT_W + 2 + WORD_W;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_ADDI  = 4'd1,
    OP_SUB   = 4'd2,
    OP_SUBI  = 4'd3,
    OP_MUL   = 4'd6,
    OP_MULI  = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd10,
    OP_JUMP  = 4'd12,
    OP_BEQZ  = 4'd13,
    OP_HALT  = 4'd14
  } op_t;

  // Decode/execute outcome handed from the ALU to the sequencer
  typedef struct packed {
    logic reg_we;
    logic pc_move;
    logic pc_ok;
    logic is_load;
    logic is_store;
    logic addr_ok;
    logic set_halt;
  } exec_ctl_t;

  function automatic logic [WORD_W-1:0] imm4(input logic [3:0] f);
    return {{(WORD_W-4){f[3]}}, f};
  endfunction

  // Signed 8-bit field halved, rounding toward zero
  function automatic logic [7:0] off8(input logic [3:0] hi, input logic [3:0] lo);
    logic [8:0] t;
    t = {hi[3], hi, lo} + {8'd0, hi[3]};
    return t[8:1];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/tcpu_ram.sv
// Single-clock RAM, one write port and one registered read port.
// Used for the unified main memory; depends on no package.
`default_nettype none

module tcpu_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcpu_regs.sv
// Register file: sixteen words, one write port, two registered read ports.
// Depends on tcpu_pkg for sizes.
`default_nettype none

module tcpu_regs (
  input  logic                          clk,
  input  logic                          we,
  input  logic [tcpu_pkg::REG_AW-1:0]   waddr,
  input  logic [tcpu_pkg::WORD_W-1:0]   wdata,
  input  logic                          re0,
  input  logic [tcpu_pkg::REG_AW-1:0]   raddr0,
  output logic [tcpu_pkg::WORD_W-1:0]   rdata0,
  input  logic                          re1,
  input  logic [tcpu_pkg::REG_AW-1:0]   raddr1,
  output logic [tcpu_pkg::WORD_W-1:0]   rdata1
);
  import tcpu_pkg::*;

  logic [WORD_W-1:0] rf [REG_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      rf[waddr] <= wdata;
    end
    if (re0) begin
      rdata0 <= rf[raddr0];
    end
    if (re1) begin
      rdata1 <= rf[raddr1];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcpu_alu.sv
// Instruction execute logic: arithmetic, data address and PC target checks.
// Depends on tcpu_pkg for opcodes, exec_ctl_t and field helpers.
`default_nettype none

module tcpu_alu #(
  parameter int MEMORY_WORDS = tcpu_pkg::MEMORY_WORDS_DEF,
  localparam int AW = $clog2(MEMORY_WORDS)
) (
  input  logic [tcpu_pkg::WORD_W-1:0] instr,
  input  logic [tcpu_pkg::WORD_W-1:0] rd0,     // R[b], or R[a] for store/beqz
  input  logic [tcpu_pkg::WORD_W-1:0] rd1,     // R[c], or R[b] for store
  input  logic [AW-1:0]               pc,
  output tcpu_pkg::exec_ctl_t         ctl,
  output logic [tcpu_pkg::WORD_W-1:0] reg_wd,
  output logic [AW-1:0]               addr,
  output logic [AW-1:0]               pc_nxt
);
  import tcpu_pkg::*;

  localparam int SW = ((AW > 7) ? AW : 7) + 2;
  localparam logic signed [SW-1:0]     MW_PC = SW'(MEMORY_WORDS);
  localparam logic signed [WORD_W-1:0] MW_DA = WORD_W'(MEMORY_WORDS);

  op_t                     op;
  logic [3:0]              fa;
  logic [3:0]              fb;
  logic [3:0]              fc;
  logic [WORD_W-1:0]       imm;
  logic [WORD_W-1:0]       mul_b;
  logic [WORD_W-1:0]       prod;
  logic signed [WORD_W:0]  dsum;
  logic signed [WORD_W:0]  drnd;
  logic signed [WORD_W-1:0] dq;
  logic signed [7:0]       delta;
  logic signed [SW-1:0]    np;

  always_comb begin
    op  = op_t'(instr[15:12]);
    fa  = instr[11:8];
    fb  = instr[7:4];
    fc  = instr[3:0];
    imm = imm4(fc);

    mul_b = (op == OP_MULI) ? imm : rd1;
    prod  = rd0 * mul_b;

    // (x + y) / 2 toward zero: add one before the shift when negative
    dsum = $signed({rd0[WORD_W-1], rd0}) + $signed({rd1[WORD_W-1], rd1});
    drnd = dsum + $signed({{WORD_W{1'b0}}, dsum[WORD_W]});
    dq   = drnd[WORD_W:1];
    addr = dq[AW-1:0];

    case (op)
      OP_JUMP: delta = off8(fa, fb);
      OP_BEQZ: delta = (rd0 == '0) ? off8(fb, fc) : 8'sd1;
      default: delta = 8'sd1;
    endcase
    np     = $signed(SW'(pc)) + SW'(delta);
    pc_nxt = np[AW-1:0];

    ctl          = '0;
    ctl.pc_ok    = !np[SW-1] && (np < MW_PC);
    ctl.addr_ok  = !dq[WORD_W-1] && (dq < MW_DA);
    reg_wd       = '0;

    case (op)
      OP_ADD: begin
        ctl.reg_we = 1'b1; ctl.pc_move = 1'b1; reg_wd = rd0 + rd1;
      end
      OP_ADDI: begin
        ctl.reg_we = 1'b1; ctl.pc_move = 1'b1; reg_wd = rd0 + imm;
      end
      OP_SUB: begin
        ctl.reg_we = 1'b1; ctl.pc_move = 1'b1; reg_wd = rd0 - rd1;
      end
      OP_SUBI: begin
        ctl.reg_we = 1'b1; ctl.pc_move = 1'b1; reg_wd = rd0 - imm;
      end
      OP_MUL, OP_MULI: begin
        ctl.reg_we = 1'b1; ctl.pc_move = 1'b1; reg_wd = prod;
      end
      OP_LOAD:  ctl.is_load  = 1'b1;
      OP_STORE: ctl.is_store = 1'b1;
      OP_JUMP, OP_BEQZ: ctl.pc_move = 1'b1;
      OP_HALT:  ctl.set_halt = 1'b1;
      default: ;  // undefined opcode: no effect
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tiny_cpu_instruction_step.sv
// Top level of the tiny CPU step block: sequencer, host access and result path.
// Depends on tcpu_pkg, tcpu_ram, tcpu_regs and tcpu_alu.
//
// Each input item writes a memory word, writes a register, reads a memory
// word, or executes the instruction at the PC; each gives exactly one result
// item. State lives in a synchronous main memory (one read, one write port)
// and a two-read-port register file, both with registered reads. Host items
// are taken one per cycle while the result path is not stalled; their result
// passes through the result slot into the output register. An executed
// instruction goes through fetch, register read and execute, and a load or
// store adds a memory step, since the data access goes through main memory;
// the next item is taken only after the instruction retires. Execute while
// halted is handled like a host item. After reset a clearing pass zeroes
// memory and registers, with in_tready held low.
`default_nettype none

module tiny_cpu_instruction_step #(
  parameter int MEMORY_WORDS = tcpu_pkg::MEMORY_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // location [8:0], write_value [24:9], zero [31:25]
  input  logic [tcpu_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode [1:0]
  input  logic [tcpu_pkg::MODE_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // next_pc [8:0], halted [9], fault [10], read_value [26:11], zero [31:27]
  output logic [tcpu_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import tcpu_pkg::*;

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int LW = ((AW > LOC_W) ? AW : LOC_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_MEM_WR = 2'd0,
    MODE_REG_WR = 2'd1,
    MODE_EXEC   = 2'd2,
    MODE_MEM_RD = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DEC   = 5'b00100,
    ST_EXE   = 5'b01000,
    ST_MEM   = 5'b10000
  } st_t;

  st_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [AW-1:0] pc_r;
  logic          halt_r;
  logic          fault_r;
  logic          s1_valid_r;
  logic          s1_rd_r;
  logic          out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic [WORD_W-1:0] instr_r;
  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     pcn_r;
  logic              pcok_r;
  logic              load_r;

  mode_t             mode;
  logic [LOC_W-1:0]  loc;
  logic [WORD_W-1:0] wval;
  logic [LW-1:0]     loc_ext;
  logic              loc_ok;
  logic [AW-1:0]     loc_addr;
  logic              accept;
  logic              exec_go;
  logic              exec_done;
  logic              mem_path;
  logic              s1_adv;
  logic [WORD_W-1:0] rd_value;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, mem_rdata;

  logic              rf_we, rf_re0, rf_re1;
  logic [REG_AW-1:0] rf_waddr, rf_raddr0, rf_raddr1;
  logic [WORD_W-1:0] rf_wdata, rf_rdata0, rf_rdata1;

  op_t               dec_op;
  exec_ctl_t         ctl;
  logic [WORD_W-1:0] alu_wd;
  logic [AW-1:0]     alu_addr;
  logic [AW-1:0]     alu_pcn;

  assign mode     = mode_t'(in_tuser);
  assign loc      = in_tdata[LOC_W-1:0];
  assign wval     = in_tdata[LOC_W +: WORD_W];
  assign loc_ext  = LW'(loc);
  assign loc_ok   = loc_ext < LW'(MEMORY_WORDS);
  assign loc_addr = loc_ext[AW-1:0];

  assign s1_adv    = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;
  assign exec_go   = accept && (mode == MODE_EXEC) && !halt_r;
  assign mem_path  = (ctl.is_load || ctl.is_store) && ctl.addr_ok;
  assign exec_done = ((state_r == ST_EXE) && !mem_path) || (state_r == ST_MEM);
  assign dec_op    = op_t'(mem_rdata[15:12]);

  tcpu_ram #(.DEPTH(MEMORY_WORDS), .WIDTH(WORD_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcpu_regs u_regs (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (rf_waddr),
    .wdata  (rf_wdata),
    .re0    (rf_re0),
    .raddr0 (rf_raddr0),
    .rdata0 (rf_rdata0),
    .re1    (rf_re1),
    .raddr1 (rf_raddr1),
    .rdata1 (rf_rdata1)
  );

  tcpu_alu #(.MEMORY_WORDS(MEMORY_WORDS)) u_alu (
    .instr  (instr_r),
    .rd0    (rf_rdata0),
    .rd1    (rf_rdata1),
    .pc     (pc_r),
    .ctl    (ctl),
    .reg_wd (alu_wd),
    .addr   (alu_addr),
    .pc_nxt (alu_pcn)
  );

  // Main memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = loc_addr;
    mem_wdata = wval;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (accept && (mode == MODE_MEM_WR) && loc_ok) begin
      mem_we = 1'b1;
    end else if ((state_r == ST_MEM) && !load_r) begin
      mem_we    = 1'b1;
      mem_waddr = addr_r;
      mem_wdata = rf_rdata0;
    end

    mem_re    = 1'b0;
    mem_raddr = loc_addr;
    if (accept && (mode == MODE_MEM_RD)) begin
      mem_re = 1'b1;
    end else if (exec_go) begin
      mem_re    = 1'b1;
      mem_raddr = pc_r;
    end else if ((state_r == ST_EXE) && ctl.is_load && ctl.addr_ok) begin
      mem_re    = 1'b1;
      mem_raddr = alu_addr;
    end
  end

  // Register file port steering
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = loc[REG_AW-1:0];
    rf_wdata = wval;
    if (state_r == ST_CLEAR) begin
      rf_we    = 1'b1;
      rf_waddr = clr_cnt_r[REG_AW-1:0];
      rf_wdata = '0;
    end else if (accept && (mode == MODE_REG_WR)) begin
      rf_we = 1'b1;
    end else if ((state_r == ST_EXE) && ctl.reg_we) begin
      rf_we    = 1'b1;
      rf_waddr = instr_r[11:8];
      rf_wdata = alu_wd;
    end else if ((state_r == ST_MEM) && load_r) begin
      rf_we    = 1'b1;
      rf_waddr = instr_r[11:8];
      rf_wdata = mem_rdata;
    end

    rf_re0    = 1'b0;
    rf_re1    = 1'b0;
    rf_raddr0 = mem_rdata[7:4];
    rf_raddr1 = mem_rdata[3:0];
    if (state_r == ST_DEC) begin
      rf_re0 = 1'b1;
      rf_re1 = 1'b1;
      if ((dec_op == OP_STORE) || (dec_op == OP_BEQZ)) begin
        rf_raddr0 = mem_rdata[11:8];
      end
      if (dec_op == OP_STORE) begin
        rf_raddr1 = mem_rdata[7:4];
      end
    end else if ((state_r == ST_EXE) && ctl.is_store && ctl.addr_ok) begin
      // store data R[c] is fetched once the address checks out
      rf_re0    = 1'b1;
      rf_raddr0 = instr_r[3:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(MEMORY_WORDS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (exec_go) state_nxt = ST_DEC;
      ST_DEC:   state_nxt = ST_EXE;
      ST_EXE:   state_nxt = mem_path ? ST_MEM : ST_IDLE;
      ST_MEM:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign rd_value = s1_rd_r ? mem_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      pc_r         <= '0;
      halt_r       <= 1'b0;
      fault_r      <= 1'b0;
      s1_valid_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end

      if (state_r == ST_EXE) begin
        if ((ctl.is_load || ctl.is_store) && !ctl.addr_ok) begin
          fault_r <= 1'b1;
          halt_r  <= 1'b1;
        end
        if (ctl.pc_move) begin
          if (ctl.pc_ok) begin
            pc_r <= alu_pcn;
          end else begin
            fault_r <= 1'b1;
            halt_r  <= 1'b1;
          end
        end
        if (ctl.set_halt) begin
          halt_r <= 1'b1;
        end
      end else if (state_r == ST_MEM) begin
        if (pcok_r) begin
          pc_r <= pcn_r;
        end else begin
          fault_r <= 1'b1;
          halt_r  <= 1'b1;
        end
      end

      if (exec_done || (accept && !exec_go)) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DEC) begin
      instr_r <= mem_rdata;
    end
    if (state_r == ST_EXE) begin
      addr_r <= alu_addr;
      pcn_r  <= alu_pcn;
      pcok_r <= ctl.pc_ok;
      load_r <= ctl.is_load;
    end
    if (exec_done) begin
      s1_rd_r <= 1'b0;
    end else if (accept) begin
      s1_rd_r <= (mode == MODE_MEM_RD) && loc_ok;
    end
    if (s1_adv) begin
      out_tdata_r <= {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, rd_value, fault_r, halt_r,
                      PC_OUT_W'(pc_r)};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A retiring instruction must find the result slot empty
  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done |-> !s1_valid_r)
    else $error("instruction retired while result slot occupied");

  a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> halt_r)
    else $error("fault raised without halt");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt cleared without reset");

  a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pc_r} < (AW+1)'(MEMORY_WORDS))
    else $error("program counter outside memory");

endmodule

`default_nettype wire
